### sv/fsp_pkg.sv
// Package for the fisheye sky-to-pixel unit: field types, fixed-point
// constants, arctangent table and small helper functions.
// No dependencies.
package fsp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_DEPTH    = 24;

	localparam int ELEV_W = 17;
	localparam int AZIM_W = 19;
	localparam int PIX_W  = 18;
	localparam int DIM_W  = 13;
	localparam int SCL_W  = 18;
	localparam int RMAX_W = 16;
	localparam int CIDX_W = 2;
	localparam int CDAT_W = 18;

	localparam int ZW = 32;  // angle, signed Q.28
	localparam int XW = 34;  // CORDIC vector components, signed Q.16
	localparam int GW = 66;  // gain product

	typedef logic        [ELEV_W-1:0] elev_t;
	typedef logic        [AZIM_W-1:0] azim_t;
	typedef logic signed [PIX_W-1:0]  pix_t;
	typedef logic        [CIDX_W-1:0] cidx_t;
	typedef logic        [CDAT_W-1:0] cdata_t;

	localparam cidx_t REG_WIDTH  = 2'd0;
	localparam cidx_t REG_HEIGHT = 2'd1;
	localparam cidx_t REG_SCALE  = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd1024;
	localparam logic [SCL_W-1:0] SCALE_RST  = 18'd65536;

	localparam logic [23:0]        TWO_OVER_PI_Q24 = 24'd10680707;
	localparam logic signed [ZW-1:0] PI_Q28      = 32'sd843314856;
	localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic signed [ZW-1:0] TWO_PI_Q28  = 32'sd1686629713;
	localparam logic signed [31:0]   INV_GAIN_Q30 = 32'sd652032874;

	localparam logic signed [PIX_W-1:0] PIX_MAX = 18'sh1FFFF;
	localparam logic signed [PIX_W-1:0] PIX_MIN = 18'sh20000;

	// atan(2^-i), Q.28
	localparam logic signed [ZW-1:0] ATAN_Q28 [ATAN_DEPTH] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
		32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
		32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
		32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
		32'sd256,       32'sd128,       32'sd64,       32'sd32
	};

	function automatic pix_t sat_pix(input logic signed [23:0] v);
		if (v > 24'(PIX_MAX))
			return PIX_MAX;
		else if (v < 24'(PIX_MIN))
			return PIX_MIN;
		else
			return v[PIX_W-1:0];
	endfunction

endpackage

### sv/fisheye_sky_to_pixel_unit.sv
// Fisheye sky-to-pixel unit: equidistant projection with a pipelined CORDIC.
// Depends on fsp_pkg.
//
// Usage
//   Sky channel (sky_valid/sky_stall, elevation, azimuth_angle): one direction
//   per beat, unsigned Q.16 radians. Pixel channel (pix_valid/pix_stall,
//   pixel_x, pixel_y): one beat per sky beat, signed Q13.4, saturated.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): width,
//   height and radius scale; cfg_ready is always high. Write only while the
//   pipeline holds no item.
//   Throughput: one beat per cycle while pix_stall does not hold the output.
//   Pipeline: five front stages (angle scaling, radius product, azimuth
//   reduction), one per CORDIC stage, then sign fix, gain multiply and
//   offset/saturate.
//   Stall: when a result waits at the output under pix_stall, the whole
//   pipeline holds and sky_stall is raised in the same cycle; nothing is
//   lost or repeated.
//   Reset: pipeline emptied, registers back to 1024 x 1024, scale 1.0.
module fisheye_sky_to_pixel_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sky_valid,
	output logic           sky_stall,
	input  fsp_pkg::elev_t elevation,
	input  fsp_pkg::azim_t azimuth_angle,
	output logic           pix_valid,
	input  logic           pix_stall,
	output fsp_pkg::pix_t  pixel_x,
	output fsp_pkg::pix_t  pixel_y,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  fsp_pkg::cidx_t cfg_index,
	input  fsp_pkg::cdata_t cfg_data
);
	import fsp_pkg::*;

	localparam int NST = 5 + CORDIC_STAGES + 3;

	logic [DIM_W-1:0]  width_q, height_q;
	logic [SCL_W-1:0]  scale_q;
	logic [RMAX_W-1:0] rmax_q;
	logic [DIM_W-1:0]  w_eff, h_eff, d_min;

	logic [NST-1:0] vld_s;
	logic           adv;

	logic [40:0]           pe_s1;
	logic [30:0]           za_s1;
	logic signed [17:0]    f_s2;
	logic signed [ZW-1:0]  zb_s2;
	logic signed [34:0]    fr_s3;
	logic signed [ZW-1:0]  z_s3;
	logic                  neg_s3;
	logic signed [53:0]    frs_s4;
	logic signed [ZW-1:0]  z_s4;
	logic                  neg_s4;

	logic signed [XW-1:0]  cx_s [CORDIC_STAGES+1];
	logic signed [XW-1:0]  cy_s [CORDIC_STAGES+1];
	logic signed [ZW-1:0]  cz_s [CORDIC_STAGES+1];
	logic                  cn_s [CORDIC_STAGES+1];

	logic signed [XW-1:0]  xn_sn, yn_sn;
	logic signed [GW-1:0]  gx_sg, gy_sg;

	logic [30:0]           z0;
	logic [40:0]           pe_rnd;
	logic [16:0]           fq;
	logic signed [ZW-1:0]  za_sgn;
	logic signed [53:0]    frs_rnd;
	logic signed [GW-1:0]  gx_rnd, gy_rnd;
	logic signed [23:0]    rx, ry, px, py;

	assign cfg_ready = 1'b1;
	assign adv       = !(pix_valid && pix_stall);
	assign sky_stall = !adv;
	assign pix_valid = vld_s[NST-1];

	assign w_eff = (width_q == '0)  ? DIM_W'(1) : width_q;
	assign h_eff = (height_q == '0) ? DIM_W'(1) : height_q;
	assign d_min = (w_eff < h_eff) ? w_eff : h_eff;

	always_comb begin
		z0      = {azimuth_angle, 12'b0};
		pe_rnd  = pe_s1 + 41'd8388608;
		fq      = pe_rnd[40:24];
		za_sgn  = $signed({1'b0, za_s1});
		frs_rnd = frs_s4 + 54'sd524288;
		gx_rnd  = gx_sg + GW'(66'sh200_0000_0000);
		gy_rnd  = gy_sg + GW'(66'sh200_0000_0000);
		rx      = gx_rnd[65:42];
		ry      = gy_rnd[65:42];
		px      = rx + $signed({8'b0, rmax_q});
		py      = $signed({8'b0, rmax_q}) - ry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			scale_q  <= SCALE_RST;
			rmax_q   <= '0;
		end else begin
			rmax_q <= {d_min[DIM_W-1:0] - DIM_W'(1), 3'b0};
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					REG_SCALE:  scale_q  <= cfg_data[SCL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[NST-2:0], sky_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// front: angle to radius factor, azimuth reduction
			pe_s1 <= 41'(elevation) * 41'(TWO_OVER_PI_Q24);
			za_s1 <= (z0 >= 31'(TWO_PI_Q28)) ? z0 - 31'(TWO_PI_Q28) : z0;

			f_s2  <= 18'sd65536 - $signed({1'b0, fq});
			zb_s2 <= (za_sgn > PI_Q28) ? za_sgn - TWO_PI_Q28 : za_sgn;

			fr_s3 <= f_s2 * $signed({1'b0, rmax_q});
			if (zb_s2 > HALF_PI_Q28) begin
				z_s3   <= zb_s2 - PI_Q28;
				neg_s3 <= 1'b1;
			end else if (zb_s2 < -HALF_PI_Q28) begin
				z_s3   <= zb_s2 + PI_Q28;
				neg_s3 <= 1'b1;
			end else begin
				z_s3   <= zb_s2;
				neg_s3 <= 1'b0;
			end

			frs_s4 <= fr_s3 * $signed({1'b0, scale_q});
			z_s4   <= z_s3;
			neg_s4 <= neg_s3;

			cx_s[0] <= XW'(frs_rnd >>> 20);
			cy_s[0] <= '0;
			cz_s[0] <= z_s4;
			cn_s[0] <= neg_s4;

			// rotation stages
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				if (!cz_s[i][ZW-1]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ATAN_Q28[i];
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ATAN_Q28[i];
				end
				cn_s[i+1] <= cn_s[i];
			end

			xn_sn <= cn_s[CORDIC_STAGES] ? -cx_s[CORDIC_STAGES] : cx_s[CORDIC_STAGES];
			yn_sn <= cn_s[CORDIC_STAGES] ? -cy_s[CORDIC_STAGES] : cy_s[CORDIC_STAGES];

			gx_sg <= GW'(xn_sn) * GW'(INV_GAIN_Q30);
			gy_sg <= GW'(yn_sn) * GW'(INV_GAIN_Q30);

			pixel_x <= sat_pix(px);
			pixel_y <= sat_pix(py);
		end
	end

endmodule

### sv/fsp_checker.sv
// Port-level checks for the fisheye sky-to-pixel unit, bound to the top level.
// Depends on fsp_pkg and fisheye_sky_to_pixel_unit.
module fsp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           sky_stall,
	input logic           pix_valid,
	input logic           pix_stall,
	input fsp_pkg::pix_t  pixel_x,
	input fsp_pkg::pix_t  pixel_y,
	input logic           cfg_valid,
	input logic           cfg_ready
);
	import fsp_pkg::*;

	// held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pixel_x) && $stable(pixel_y))
		else $error("held pixel beat changed");

	// a waiting result backs up the sky side
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |-> sky_stall)
		else $error("sky side not stalled behind a held result");

	// empty output never stalls the sky side
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_valid |-> !sky_stall)
		else $error("sky stalled with output free");

	// config always taken
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind fisheye_sky_to_pixel_unit fsp_checker u_fsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.sky_stall (sky_stall),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

### tb/fisheye_sky_to_pixel_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for fisheye_sky_to_pixel_unit: directed and random sky directions over several
// image geometries, every pixel beat checked against a fixed-point projection kept here.
// Depends on fsp_pkg and the unit.
module fisheye_sky_to_pixel_unit_tb;

	localparam longint ANG_PI          = 843314856;
	localparam longint ANG_HALF_PI     = 421657428;
	localparam longint ANG_TWO_PI      = 1686629713;
	localparam longint ANG_QUARTER_PI  = 210828714;
	localparam longint ELEV_TO_UNIT    = 10680707;
	localparam longint CORDIC_GAIN_INV = 652032874;
	localparam longint PIX_HI          = 131071;
	localparam longint PIX_LO          = -131072;
	localparam int     CYCLE_LIMIT     = 200000;
	localparam int     DRAIN_CYCLES    = 40;

	localparam fsp_pkg::cidx_t REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct {
		fsp_pkg::elev_t elev;
		fsp_pkg::azim_t azim;
	} sky_beat_t;

	typedef struct {
		fsp_pkg::pix_t x;
		fsp_pkg::pix_t y;
	} pixel_pair_t;

	logic            clk;
	logic            arst_n        = 1'b0;
	logic            sky_valid     = 1'b0;
	logic            sky_stall;
	fsp_pkg::elev_t  elevation     = '0;
	fsp_pkg::azim_t  azimuth_angle = '0;
	logic            pix_valid;
	logic            pix_stall     = 1'b0;
	fsp_pkg::pix_t   pixel_x;
	fsp_pkg::pix_t   pixel_y;
	logic            cfg_valid     = 1'b0;
	logic            cfg_ready;
	fsp_pkg::cidx_t  cfg_index     = fsp_pkg::REG_WIDTH;
	fsp_pkg::cdata_t cfg_data      = '0;

	logic [fsp_pkg::DIM_W-1:0] img_w   = fsp_pkg::WIDTH_RST;
	logic [fsp_pkg::DIM_W-1:0] img_h   = fsp_pkg::HEIGHT_RST;
	logic [fsp_pkg::SCL_W-1:0] r_scale = fsp_pkg::SCALE_RST;

	sky_beat_t   sky_pending[$];
	pixel_pair_t pixel_due[$];
	sky_beat_t   next_beat;
	pixel_pair_t want;
	logic        sky_taken      = 1'b0;
	int          burst_left     = 0;
	int          gap_left       = 0;
	stall_mode_t stall_mode     = STALL_NONE;
	int          stall_left     = 0;
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	fisheye_sky_to_pixel_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sky_valid     (sky_valid),
		.sky_stall     (sky_stall),
		.elevation     (elevation),
		.azimuth_angle (azimuth_angle),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// atan(2^-i) in Q.28 from the alternating series in Q.60
	function automatic longint arctan_q28(input int i);
		longint sum;
		longint term;
		int k;
		if (i == 0)
			return ANG_QUARTER_PI;
		sum = 0;
		for (k = 1; i * k <= 60; k += 2) begin
			term = (longint'(1) <<< (60 - i * k)) / k;
			if (((k >> 1) & 1) != 0)
				sum -= term;
			else
				sum += term;
		end
		return (sum + (longint'(1) <<< 31)) >>> 32;
	endfunction

	function automatic fsp_pkg::pix_t clamp_pix(input longint v);
		if (v > PIX_HI)
			return fsp_pkg::pix_t'(PIX_HI);
		if (v < PIX_LO)
			return fsp_pkg::pix_t'(PIX_LO);
		return fsp_pkg::pix_t'(v);
	endfunction

	function automatic pixel_pair_t project_sky(input fsp_pkg::elev_t el, input fsp_pkg::azim_t az);
		longint w, h, rmax, f, r, x, y, z, dx, dy, vx, vy;
		bit flip;
		int i;
		pixel_pair_t res;
		w = (img_w == 0) ? longint'(1) : longint'(img_w);
		h = (img_h == 0) ? longint'(1) : longint'(img_h);
		rmax = 8 * (((w < h) ? w : h) - 1);
		f = 65536 - ((longint'(el) * ELEV_TO_UNIT + (longint'(1) <<< 23)) >>> 24);
		r = (f * rmax * longint'(r_scale) + (longint'(1) <<< 19)) >>> 20;
		z = longint'(az) <<< 12;
		flip = 1'b0;
		if (z >= ANG_TWO_PI)
			z -= ANG_TWO_PI;
		if (z > ANG_PI)
			z -= ANG_TWO_PI;
		if (z > ANG_HALF_PI) begin
			z -= ANG_PI;
			flip = 1'b1;
		end else if (z < -ANG_HALF_PI) begin
			z += ANG_PI;
			flip = 1'b1;
		end
		x = r;
		y = 0;
		for (i = 0; i < fsp_pkg::CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan_q28(i);
			end else begin
				x += dx;
				y -= dy;
				z += arctan_q28(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		vx = ((x * CORDIC_GAIN_INV + (longint'(1) <<< 41)) >>> 42) + rmax;
		vy = rmax - ((y * CORDIC_GAIN_INV + (longint'(1) <<< 41)) >>> 42);
		res.x = clamp_pix(vx);
		res.y = clamp_pix(vy);
		return res;
	endfunction

	// sky driver: bursts of beats with random gaps
	always @(negedge clk) begin
		if (!sky_valid || sky_taken) begin
			if (gap_left != 0) begin
				sky_valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (sky_pending.size() != 0) begin
				next_beat = sky_pending.pop_front();
				sky_valid     <= 1'b1;
				elevation     <= next_beat.elev;
				azimuth_angle <= next_beat.azim;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else
					burst_left <= burst_left - 1;
			end else
				sky_valid <= 1'b0;
		end
	end

	// pixel back-pressure: none, light, heavy or periodic, the mode redrawn at random
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 120);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			STALL_NONE:  pix_stall <= 1'b0;
			STALL_LIGHT: pix_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: pix_stall <= ($urandom_range(0, 9) < 7);
			default:     pix_stall <= ((stall_left % 5) < 2);
		endcase
	end

	always @(posedge clk) begin
		sky_taken <= sky_valid && !sky_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fsp_pkg::REG_WIDTH:  img_w   <= cfg_data[fsp_pkg::DIM_W-1:0];
					fsp_pkg::REG_HEIGHT: img_h   <= cfg_data[fsp_pkg::DIM_W-1:0];
					fsp_pkg::REG_SCALE:  r_scale <= cfg_data[fsp_pkg::SCL_W-1:0];
					default: ;
				endcase
			end
			if (sky_valid && !sky_stall)
				pixel_due.push_back(project_sky(elevation, azimuth_angle));
			if (pix_valid && !pix_stall) begin
				if (pixel_due.size() == 0) begin
					$error("pixel beat with nothing expected: x %0d y %0d", pixel_x, pixel_y);
					mismatch_count++;
				end else begin
					want = pixel_due.pop_front();
					if (pixel_x !== want.x) begin
						$error("pixel_x: expected %0d, actual %0d", want.x, pixel_x);
						mismatch_count++;
					end
					if (pixel_y !== want.y) begin
						$error("pixel_y: expected %0d, actual %0d", want.y, pixel_y);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input fsp_pkg::cidx_t idx, input int unsigned value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= fsp_pkg::cdata_t'(value);
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_sky(input int unsigned el, input int unsigned az);
		sky_beat_t b;
		b.elev = fsp_pkg::elev_t'(el);
		b.azim = fsp_pkg::azim_t'(az);
		sky_pending.push_back(b);
	endtask

	task automatic add_random_sky(input int n);
		int unsigned el, az, pick;
		repeat (n) begin
			pick = $urandom_range(0, 9);
			if (pick < 8)
				el = $urandom_range(0, 102944);
			else if (pick == 8)
				el = $urandom_range(0, 131071);
			else
				el = ($urandom_range(0, 1) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 102944 : 131071);
			az = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 524287) : $urandom_range(0, 411775);
			push_sky(el, az);
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (sky_pending.size() != 0 || sky_valid || pixel_due.size() != 0);
	endtask

	task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned s,
		input int n);
		write_reg(fsp_pkg::REG_WIDTH, w);
		write_reg(fsp_pkg::REG_HEIGHT, h);
		write_reg(fsp_pkg::REG_SCALE, s);
		add_random_sky(n);
		wait_idle();
	endtask

	initial begin
		int p;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: horizon, zenith, past zenith, azimuth folds and wrap
		push_sky(0, 0);
		push_sky(0, 102943);
		push_sky(0, 102944);
		push_sky(0, 205887);
		push_sky(0, 205888);
		push_sky(0, 308831);
		push_sky(0, 308832);
		push_sky(0, 411775);
		push_sky(0, 411776);
		push_sky(0, 524287);
		push_sky(102944, 0);
		push_sky(131071, 0);
		push_sky(131071, 205887);
		push_sky(51472, 51472);
		push_sky(65535, 262143);
		push_sky(1, 1);
		push_sky(131071, 524287);
		add_random_sky(60);
		wait_idle();

		run_phase(8191, 8191, 262143, 70);
		run_phase(0, 0, 65536, 40);
		run_phase(4096, 640, 0, 50);
		run_phase(1, 4096, 131072, 50);

		for (p = 0; p < 5; p++) begin
			write_reg(REG_UNUSED, $urandom_range(0, 262143));
			run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 131072),
				70);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
